### hdl/pdhe_pkg.sv
// Shared types and constants for the pixel difference histogram engine.
// Used by the top level and its port checker; depends on nothing else.
package pdhe_pkg;

	// Sample and bin geometry
	localparam int SAMPLE_BITS     = 8;
	localparam int MAX_SAMPLE      = 255;
	localparam int ROW_BITS        = 8;
	localparam int COL_BITS        = 9;
	localparam int ADDR_BITS       = ROW_BITS + COL_BITS;
	localparam int STORE_DEPTH     = 1 << ADDR_BITS;
	localparam int BIN_COUNT_BITS  = 32;
	localparam int COUNT_WIDTH_DEF = 32;

	// Request commands
	localparam int CMD_BITS = 2;
	localparam logic [CMD_BITS-1:0] CMD_COUNT = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

	// Histogram modes
	localparam int MODE_BITS = 2;
	localparam logic [MODE_BITS-1:0] MODE_VALUE = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_DIFF  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_JOINT = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]    command;
		logic [SAMPLE_BITS-1:0] src_pixel;
		logic [SAMPLE_BITS-1:0] dest_pixel;
		logic [ROW_BITS-1:0]    read_row;
		logic [COL_BITS-1:0]    read_column;
	} in_t;

	typedef struct packed {
		logic [BIN_COUNT_BITS-1:0] bin_count;
		logic                      bin_saturated;
	} out_t;

endpackage

### hdl/pixel_difference_histogram_engine.sv
// Top level of the pixel difference histogram engine.
// Depends on pdhe_pkg and on pdhe_ram for the bin store.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets the histogram mode; write it
//   only while the engine is idle. cfg_ready is always high.
//   in channel carries one request: count a pixel pair, read a bin, or clear.
//   out channel returns one result (bin_count, bin_saturated) per read request.
// Throughput: count requests are taken one per cycle outside a clearing sweep;
//   a read waits while the previous read is in stage 1. The bin store is a single
//   RAM with a registered read; a count's read-modify-write ends in the cycle after
//   acceptance; a write in flight is forwarded to a later request on the same bin.
// Read path: a read goes through stage 1, where the bin store is read, then the
//   output register that holds its result. A read request waits while the
//   output register holds an untaken result or while the previous read is still
//   in flight; counts keep flowing meanwhile.
// Reset and clear: after reset, and after each clear request, the engine
//   sweeps zeros through all 131072 bins, one per cycle, with in_ready low until
//   the sweep ends. The mode resets to the reference value histogram.
// Stall: when out_ready is low, the result stays in the output register.
module pixel_difference_histogram_engine import pdhe_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MODE_BITS-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data
);

	typedef enum logic {ST_CLEAR, ST_RUN} state_t;

	state_t                 state_q;
	logic [ADDR_BITS-1:0]   clr_addr_q;
	logic [MODE_BITS-1:0]   mode_q;
	logic                   out_valid_q;
	out_t                   out_data_q;

	// Stage 1: request whose bin is being read from the store
	logic                   v_s1;
	logic                   cnt_s1;
	logic                   zero_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic                   fwd_s1;
	logic [COUNT_WIDTH-1:0] fwd_data_s1;

	logic [COL_BITS-1:0]    offset;
	logic [ADDR_BITS-1:0]   cnt_addr;
	logic [ADDR_BITS-1:0]   rd_addr;
	logic [ADDR_BITS-1:0]   req_addr;
	logic                   mode_ok;
	logic                   is_count;
	logic                   is_read;
	logic                   is_clear;
	logic                   out_room;
	logic                   accept;
	logic                   enter_s1;
	logic                   wr_cnt;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] cur_val;
	logic                   cur_sat;
	logic [COUNT_WIDTH-1:0] inc_val;
	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	assign cfg_ready = 1'b1;

	// Decode the request
	assign is_count = (in_data.command == CMD_COUNT);
	assign is_read  = (in_data.command == CMD_READ);
	assign is_clear = (in_data.command == CMD_CLEAR);

	// Difference offset dest - src + MAX_SAMPLE, always within 0..510
	assign offset = {1'b0, in_data.dest_pixel} + COL_BITS'(MAX_SAMPLE)
		- {1'b0, in_data.src_pixel};

	// Map the request onto a store address for the current mode
	always_comb begin
		mode_ok  = 1'b1;
		cnt_addr = '0;
		rd_addr  = '0;
		case (mode_q)
			MODE_VALUE: begin
				cnt_addr = ADDR_BITS'(in_data.src_pixel);
				rd_addr  = ADDR_BITS'(in_data.read_row);
			end
			MODE_DIFF: begin
				cnt_addr = ADDR_BITS'(offset);
				rd_addr  = ADDR_BITS'(in_data.read_column);
			end
			MODE_JOINT: begin
				cnt_addr = {in_data.src_pixel, offset};
				rd_addr  = {in_data.read_row, in_data.read_column};
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
	end

	assign req_addr = is_count ? cnt_addr : rd_addr;

	// Admit a read only when its result has a free output slot
	assign out_room = !(out_valid_q && !out_ready) && !(v_s1 && !cnt_s1);
	assign in_ready = (state_q == ST_RUN) && (!is_read || out_room);
	assign accept   = in_valid && in_ready;
	assign enter_s1 = accept && ((is_count && mode_ok) || is_read);

	// Read-modify-write of the counted bin, with forwarding of the last write
	assign cur_val = fwd_s1 ? fwd_data_s1 : rd_data;
	assign cur_sat = &cur_val;
	assign inc_val = cur_sat ? cur_val : cur_val + COUNT_WIDTH'(1);
	assign wr_cnt  = v_s1 && cnt_s1;

	// Clearing sweep owns the write port while it runs
	assign ram_we    = (state_q == ST_CLEAR) || wr_cnt;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : inc_val;

	pdhe_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (req_addr),
		.rdata (rd_data)
	);

	// Control state, mode register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			mode_q      <= MODE_VALUE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
					if (&clr_addr_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (accept && is_clear) begin
						state_q    <= ST_CLEAR;
						clr_addr_q <= '0;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			v_s1 <= enter_s1;
			if (v_s1 && !cnt_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage payload and result register
	always_ff @(posedge clk) begin
		if (enter_s1) begin
			cnt_s1      <= is_count;
			zero_s1     <= !mode_ok;
			addr_s1     <= req_addr;
			fwd_s1      <= wr_cnt && (addr_s1 == req_addr);
			fwd_data_s1 <= inc_val;
		end
		if (v_s1 && !cnt_s1) begin
			out_data_q.bin_count     <= zero_s1 ? '0 : BIN_COUNT_BITS'(cur_val);
			out_data_q.bin_saturated <= !zero_s1 && cur_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hdl/pdhe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module pdhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; a read of the entry being written returns the old value
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/pdhe_checker.sv
// Port-level checker for the pixel difference histogram engine, with its bind.
// Depends on pdhe_pkg for the payload types and command codes.
module pdhe_checker import pdhe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Refuse a read request while a result waits untaken
	a_read_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && (in_data.command == CMD_READ) && out_valid && !out_ready
		|-> !in_ready)
		else $error("read request taken with no room for its result");

	// Drop ready once a clear request starts its sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.command == CMD_CLEAR) |=> !in_ready)
		else $error("request taken during clearing sweep");

	// Raise a result only for an accepted read request that has passed stage 1
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
		$past(in_valid && in_ready && (in_data.command == CMD_READ), 2))
		else $error("result without a matching read request");

endmodule

bind pixel_difference_histogram_engine pdhe_checker u_checker (.*);

### bench/tb.sv
// Self-checking bench for pixel_difference_histogram_engine.
// Drives count, read and clear requests, predicts every bin read and checks it.
// Depends on pdhe_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb import pdhe_pkg::*; ();

	// Bin counters at the default width
	localparam int          BIN_W         = COUNT_WIDTH_DEF;
	localparam longint unsigned BIN_MAX   = (64'd1 << BIN_W) - 1;
	localparam logic [CMD_BITS-1:0]  CMD_NONE    = 2'd3;
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          TAIL_CYCLES   = 20;
	localparam int unsigned CYCLE_LIMIT   = 4_000_000;

	typedef struct {
		logic [MODE_BITS-1:0] mode;
		in_t                  req;
		bit                   want_zero;
	} probe_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [MODE_BITS-1:0] cfg_data  = MODE_VALUE;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;

	// Bench state: mirror of the bin store and the mode register
	longint unsigned      bin_store [int];
	logic [MODE_BITS-1:0] hist_mode = MODE_VALUE;
	out_t                 pending_bins [$];
	logic [7:0]           hot_src [8];
	logic [7:0]           hot_dst [8];
	int                   send_gap_pct   = 0;
	int                   recv_stall_pct = 0;
	int                   clears_left    = 2;
	int                   clears_seen    = 0;
	int                   requests_sent  = 0;
	int                   reads_checked  = 0;
	int                   mismatch_count = 0;
	int unsigned          cycle_count    = 0;

	pixel_difference_histogram_engine #(
		.COUNT_WIDTH(BIN_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Map a row and column to a store address for the given mode
	function automatic int bin_addr(input logic [MODE_BITS-1:0] m, input int row, input int col);
		if (m == MODE_VALUE)
			return row & 255;
		if (m == MODE_DIFF)
			return col & 511;
		return ((row & 255) * (1 << COL_BITS) + (col & 511)) & (STORE_DEPTH - 1);
	endfunction

	function automatic longint unsigned bin_value(input int addr);
		return bin_store.exists(addr) ? bin_store[addr] : 64'd0;
	endfunction

	// Apply one request to the mirror; return the read result if it makes one
	function automatic void histogram_step(input in_t r, output bit has_res, output out_t res);
		int              offset;
		int              addr;
		longint unsigned v;
		has_res = 1'b0;
		res     = '0;
		case (r.command)
			CMD_COUNT: begin
				if (hist_mode != MODE_UNUSED) begin
					offset = int'(r.dest_pixel) + MAX_SAMPLE - int'(r.src_pixel);
					addr   = bin_addr(hist_mode, int'(r.src_pixel), offset);
					v      = bin_value(addr);
					if (v < BIN_MAX)
						bin_store[addr] = v + 1;
				end
			end
			CMD_READ: begin
				has_res = 1'b1;
				if (hist_mode != MODE_UNUSED) begin
					v = bin_value(bin_addr(hist_mode, int'(r.read_row), int'(r.read_column)));
					res.bin_count     = v[BIN_COUNT_BITS-1:0];
					res.bin_saturated = (v == BIN_MAX);
				end
			end
			CMD_CLEAR: begin
				bin_store.delete();
				clears_seen++;
			end
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endfunction

	function automatic probe_t probe(input logic [MODE_BITS-1:0] m, input logic [CMD_BITS-1:0] c,
			input int s, input int d, input int row, input int col, input bit want_zero);
		probe_t p;
		p.mode                = m;
		p.req.command         = c;
		p.req.src_pixel       = s[7:0];
		p.req.dest_pixel      = d[7:0];
		p.req.read_row        = row[7:0];
		p.req.read_column     = col[8:0];
		p.want_zero           = want_zero;
		return p;
	endfunction

	// Random request, mostly aimed at a small pool of pixel values so reads hit live bins
	function automatic in_t random_request();
		in_t r;
		int  pick;
		int  s;
		int  d;
		r.command     = CMD_COUNT;
		r.src_pixel   = 8'($urandom);
		r.dest_pixel  = 8'($urandom);
		r.read_row    = 8'($urandom);
		r.read_column = 9'($urandom_range(511));
		s = hot_src[$urandom_range(7)];
		d = hot_dst[$urandom_range(7)];
		pick = $urandom_range(99);
		if (pick < 58) begin
			if ($urandom_range(99) < 65) begin
				r.src_pixel  = s[7:0];
				r.dest_pixel = d[7:0];
			end
		end else if (pick < 93) begin
			r.command = CMD_READ;
			if ($urandom_range(99) < 50) begin
				r.read_row    = s[7:0];
				r.read_column = 9'(d + MAX_SAMPLE - s);
			end
		end else if (pick < 97) begin
			r.command = CMD_NONE;
		end else if (clears_left > 0) begin
			r.command = CMD_CLEAR;
			clears_left--;
		end
		return r;
	endfunction

	// Drop the request line
	task automatic idle_request();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_bins.size() != 0)
			@(posedge clk);
	endtask

	// Send one request, with random idle cycles ahead of it, and record its expectation
	task automatic send_request(input in_t r, input bit want_zero);
		bit   has_res;
		out_t res;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		histogram_step(r, has_res, res);
		if (has_res)
			pending_bins.push_back(want_zero ? out_t'('0) : res);
	endtask

	// Write the mode register once the engine has gone quiet
	task automatic write_mode(input logic [MODE_BITS-1:0] m);
		idle_request();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hist_mode = m;
	endtask

	task automatic run_phase(input logic [MODE_BITS-1:0] m, input int send_pct, input int recv_pct,
			input int items, input int pause_at);
		write_mode(m);
		send_gap_pct   = send_pct;
		recv_stall_pct = recv_pct;
		foreach (hot_src[k]) begin
			hot_src[k] = 8'($urandom);
			hot_dst[k] = 8'($urandom);
		end
		for (int i = 0; i < items; i++) begin
			// Hold off until every outstanding read has returned
			if (i == pause_at) begin
				idle_request();
				wait_drained();
			end
			send_request(random_request(), 1'b0);
		end
	endtask

	// Receiver: stall at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every returned bin against the oldest expectation
	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bins.size() == 0) begin
				note_mismatch($sformatf("unexpected result count %0d sat %0b",
					out_data.bin_count, out_data.bin_saturated));
			end else begin
				want = pending_bins.pop_front();
				reads_checked++;
				if (out_data.bin_count !== want.bin_count)
					note_mismatch($sformatf("bin_count expected %0d got %0d",
						want.bin_count, out_data.bin_count));
				if (out_data.bin_saturated !== want.bin_saturated)
					note_mismatch($sformatf("bin_saturated expected %0b got %0b",
						want.bin_saturated, out_data.bin_saturated));
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : run_stimulus
		probe_t probes [$];

		// Reference value histogram right after reset
		probes.push_back(probe(MODE_VALUE,  CMD_READ,    0,   0,   0,   0, 1'b1));
		probes.push_back(probe(MODE_VALUE,  CMD_COUNT,   0,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_VALUE,  CMD_COUNT, 255, 255, 255, 511, 1'b0));
		probes.push_back(probe(MODE_VALUE,  CMD_READ,  255, 255,   0, 511, 1'b0));
		probes.push_back(probe(MODE_VALUE,  CMD_READ,    0,   0, 255,   0, 1'b0));
		// Difference histogram shares the store with the value bins
		probes.push_back(probe(MODE_DIFF,   CMD_COUNT,   0, 255,   0,   0, 1'b0));
		probes.push_back(probe(MODE_DIFF,   CMD_COUNT, 255,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_DIFF,   CMD_COUNT, 128, 128,   0,   0, 1'b0));
		probes.push_back(probe(MODE_DIFF,   CMD_READ,    0,   0,   0, 510, 1'b0));
		probes.push_back(probe(MODE_DIFF,   CMD_READ,    0,   0, 255,   0, 1'b0));
		probes.push_back(probe(MODE_DIFF,   CMD_READ,    0,   0,   0, 511, 1'b1));
		probes.push_back(probe(MODE_DIFF,   CMD_NONE,  255, 255, 255, 511, 1'b0));
		// Joint histogram, then a clear
		probes.push_back(probe(MODE_JOINT,  CMD_COUNT, 255,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_JOINT,  CMD_COUNT, 255,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_JOINT,  CMD_READ,    0,   0, 255,   0, 1'b0));
		probes.push_back(probe(MODE_JOINT,  CMD_READ,    0,   0,   0, 255, 1'b0));
		probes.push_back(probe(MODE_JOINT,  CMD_READ,    0,   0, 255, 511, 1'b1));
		probes.push_back(probe(MODE_JOINT,  CMD_CLEAR,   0,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_JOINT,  CMD_READ,    0,   0, 255,   0, 1'b1));
		// Unused mode ignores counts and reads back zero
		probes.push_back(probe(MODE_UNUSED, CMD_COUNT,   1,   2,   0,   0, 1'b0));
		probes.push_back(probe(MODE_UNUSED, CMD_READ,    0,   0,   1, 258, 1'b1));
		probes.push_back(probe(MODE_UNUSED, CMD_NONE,    0,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_VALUE,  CMD_READ,    0,   0,   1,   0, 1'b1));
		probes.push_back(probe(MODE_VALUE,  CMD_COUNT, 255,   0,   0,   0, 1'b0));
		probes.push_back(probe(MODE_VALUE,  CMD_READ,    0,   0, 255,   0, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (probes[i]) begin
			if (probes[i].mode != hist_mode)
				write_mode(probes[i].mode);
			send_request(probes[i].req, probes[i].want_zero);
		end

		// Random traffic under each idling pattern
		run_phase(MODE_JOINT,  0,  0,  200, -1);
		run_phase(MODE_DIFF,   46, 0,  200, 90);
		run_phase(MODE_VALUE,  0,  46, 200, -1);
		run_phase(MODE_UNUSED, 35, 35, 120, -1);
		run_phase(MODE_JOINT,  35, 35, 200, -1);

		idle_request();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests in all four modes with %0d clears and random stalls;",
			requests_sent, clears_seen);
		$display("checked %0d bin reads, %0d mismatches.", reads_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
